FILE: rtl/audio_mix_accumulator_macros.svh
// ----------------------------------------------------------------------------
// Audio mix accumulator assertion macros
// Shared macros for concurrent assertions on the mix accumulator ports.
// ----------------------------------------------------------------------------
`ifndef AUDIO_MIX_ACCUMULATOR_MACROS_SVH
`define AUDIO_MIX_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define AMACC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("amacc assertion failed");

// next-cycle implication
`define AMACC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("amacc assertion failed");

`endif

FILE: rtl/amacc_pkg.sv
// ----------------------------------------------------------------------------
// Audio mix accumulator package
// Sizes, codes and payload types shared by the mix accumulator modules.
// ----------------------------------------------------------------------------
package amacc_pkg;

    localparam int BUF_DEPTH  = 4096;
    localparam int ACC_WIDTH  = 24;
    localparam int MAX_STRIDE = 8;
    localparam int Q15_ONE    = 32767;

    localparam int ADDR_W = $clog2(BUF_DEPTH);
    localparam int POS_W  = (ADDR_W + 1 > 12) ? ADDR_W + 1 : 12;
    localparam int STEP_W = $clog2(MAX_STRIDE + 1);

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_MIX   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef logic [ADDR_W-1:0]           addr_t;
    typedef logic [POS_W-1:0]            pos_t;
    typedef logic [STEP_W-1:0]           step_t;
    typedef logic signed [ACC_WIDTH-1:0] acc_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [11:0]        offset;
        logic [3:0]         stride;
        logic signed [15:0] sample;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] clamped_sample;
        logic signed [23:0] raw_sum;
        logic               last;
        logic               empty_res;
    } res_t;

    typedef struct packed {
        logic  rd_en;
        addr_t rd_addr;
        logic  wr_en;
        addr_t wr_addr;
        acc_t  wr_data;
    } mem_req_t;

endpackage

FILE: rtl/amacc_mem.sv
// ----------------------------------------------------------------------------
// Audio mix accumulator store
// Accumulator memory with registered read and a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module amacc_mem (
    input  logic                clk,
    input  logic                rst_n,
    input  amacc_pkg::mem_req_t req,
    output amacc_pkg::acc_t     rd_data,
    output logic                clearing
);

    amacc_pkg::acc_t  mem [amacc_pkg::BUF_DEPTH];
    amacc_pkg::acc_t  rd_data_reg;
    amacc_pkg::addr_t clr_addr_reg;
    logic             clr_busy_reg;

    logic             wr_en;
    amacc_pkg::addr_t wr_addr;
    amacc_pkg::acc_t  wr_data;

    always_comb
    begin
        if (clr_busy_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = req.wr_en;
            wr_addr = req.wr_addr;
            wr_data = req.wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == amacc_pkg::addr_t'(amacc_pkg::BUF_DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_busy_reg;

endmodule

FILE: rtl/amacc_core.sv
// ----------------------------------------------------------------------------
// Audio mix accumulator core
// Position tracking, read-modify-write of accumulators and result register.
// ----------------------------------------------------------------------------
module amacc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  amacc_pkg::cmd_t     cmd,
    output logic                res_valid,
    input  logic                res_ready,
    output amacc_pkg::res_t     res,
    output amacc_pkg::mem_req_t mem_req,
    input  amacc_pkg::acc_t     rd_data,
    input  logic                clearing
);

    localparam amacc_pkg::acc_t ACC_HI = amacc_pkg::acc_t'(amacc_pkg::Q15_ONE);
    localparam amacc_pkg::acc_t ACC_LO = amacc_pkg::acc_t'(-amacc_pkg::Q15_ONE);
    localparam amacc_pkg::pos_t DEPTH_POS = amacc_pkg::pos_t'(amacc_pkg::BUF_DEPTH);

    function automatic amacc_pkg::acc_t sat_add(amacc_pkg::acc_t a, logic signed [15:0] s);
        logic signed [amacc_pkg::ACC_WIDTH:0] sum;
        sum = (amacc_pkg::ACC_WIDTH + 1)'(a) + (amacc_pkg::ACC_WIDTH + 1)'(s);
        if (sum[amacc_pkg::ACC_WIDTH] != sum[amacc_pkg::ACC_WIDTH-1])
        begin
            return sum[amacc_pkg::ACC_WIDTH] ? {1'b1, {(amacc_pkg::ACC_WIDTH-1){1'b0}}}
                                             : {1'b0, {(amacc_pkg::ACC_WIDTH-1){1'b1}}};
        end
        return sum[amacc_pkg::ACC_WIDTH-1:0];
    endfunction

    logic             busy_reg,      busy_next;
    amacc_pkg::cmd_t  item_reg;
    amacc_pkg::pos_t  wpos_reg,      wpos_next;
    amacc_pkg::step_t step_reg,      step_next;
    amacc_pkg::pos_t  used_reg,      used_next;
    amacc_pkg::pos_t  rpos_reg,      rpos_next;
    logic             res_valid_reg, res_valid_next;
    amacc_pkg::res_t  res_reg,       res_next;

    logic                       accept;
    logic                       done;
    logic                       is_read;
    logic [amacc_pkg::POS_W:0]  wpos_sum;
    amacc_pkg::pos_t            rpos_inc;
    amacc_pkg::acc_t            clamped;
    logic signed [31:0]         raw_ext;

    assign cmd_ready = !busy_reg && !clearing;
    assign accept    = cmd_valid && cmd_ready;
    assign is_read   = (item_reg.op == amacc_pkg::OP_READ);
    assign done      = busy_reg && (!is_read || !res_valid_reg || res_ready);

    assign wpos_sum   = {1'b0, wpos_reg} + (amacc_pkg::POS_W + 1)'(step_reg);
    assign rpos_inc   = rpos_reg + 1'b1;
    assign raw_ext    = 32'(rd_data);

    always_comb
    begin
        if (rd_data > ACC_HI)
        begin
            clamped = ACC_HI;
        end
        else if (rd_data < ACC_LO)
        begin
            clamped = ACC_LO;
        end
        else
        begin
            clamped = rd_data;
        end
    end

    always_comb
    begin
        mem_req.rd_en   = accept;
        mem_req.rd_addr = (cmd.op == amacc_pkg::OP_MIX) ? wpos_reg[amacc_pkg::ADDR_W-1:0]
                                                         : rpos_reg[amacc_pkg::ADDR_W-1:0];
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = wpos_reg[amacc_pkg::ADDR_W-1:0];
        mem_req.wr_data = sat_add(rd_data, item_reg.sample);

        busy_next      = busy_reg;
        wpos_next      = wpos_reg;
        step_next      = step_reg;
        used_next      = used_reg;
        rpos_next      = rpos_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;

        if (accept)
        begin
            busy_next = 1'b1;
        end

        if (done)
        begin
            busy_next = 1'b0;
            case (item_reg.op)
                amacc_pkg::OP_BEGIN:
                begin
                    wpos_next = amacc_pkg::pos_t'(item_reg.offset);
                    if (item_reg.stride == 4'd0)
                    begin
                        step_next = amacc_pkg::step_t'(1);
                    end
                    else if ({1'b0, item_reg.stride} > 5'(amacc_pkg::MAX_STRIDE))
                    begin
                        step_next = amacc_pkg::step_t'(amacc_pkg::MAX_STRIDE);
                    end
                    else
                    begin
                        step_next = amacc_pkg::step_t'(item_reg.stride);
                    end
                end
                amacc_pkg::OP_MIX:
                begin
                    if (wpos_reg < DEPTH_POS)
                    begin
                        mem_req.wr_en = 1'b1;
                        if (used_reg < wpos_reg + 1'b1)
                        begin
                            used_next = wpos_reg + 1'b1;
                        end
                        if (wpos_sum > (amacc_pkg::POS_W + 1)'(amacc_pkg::BUF_DEPTH))
                        begin
                            wpos_next = DEPTH_POS;
                        end
                        else
                        begin
                            wpos_next = wpos_sum[amacc_pkg::POS_W-1:0];
                        end
                    end
                end
                amacc_pkg::OP_READ:
                begin
                    res_valid_next = 1'b1;
                    if (used_reg == '0 || rpos_reg >= used_reg || rpos_reg >= DEPTH_POS)
                    begin
                        res_next = '{clamped_sample: '0, raw_sum: '0, last: 1'b0,
                                     empty_res: 1'b1};
                        if (used_reg == '0)
                        begin
                            rpos_next = '0;
                        end
                    end
                    else
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = rpos_reg[amacc_pkg::ADDR_W-1:0];
                        mem_req.wr_data = '0;
                        res_next.clamped_sample = 16'(clamped);
                        res_next.raw_sum        = raw_ext[23:0];
                        res_next.empty_res      = 1'b0;
                        res_next.last           = (rpos_inc >= used_reg);
                        if (rpos_inc >= used_reg)
                        begin
                            used_next = '0;
                            rpos_next = '0;
                        end
                        else
                        begin
                            rpos_next = rpos_inc;
                        end
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            wpos_reg      <= '0;
            step_reg      <= amacc_pkg::step_t'(1);
            used_reg      <= '0;
            rpos_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            wpos_reg      <= wpos_next;
            step_reg      <= step_next;
            used_reg      <= used_next;
            rpos_reg      <= rpos_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd;
        end
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: rtl/audio_mix_accumulator.sv
// ----------------------------------------------------------------------------
// Audio mix accumulator
// Saturating mix buffer: begin, mix and drain-read over one accumulator store.
// ----------------------------------------------------------------------------
// Each command starts with its transfer cycle, which issues the accumulator
// read to the single-port-read store, and the next cycle modifies the value,
// writes it back and loads the result register; a new command is taken only
// once the last one is done. A read command also waits in that cycle while an
// earlier result is still held in the output register. After reset the store
// is zeroed by a sweep over all BUF_DEPTH entries, during which cmd_ready is low.
module audio_mix_accumulator (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  amacc_pkg::cmd_t cmd,
    output logic            res_valid,
    input  logic            res_ready,
    output amacc_pkg::res_t res
);

    amacc_pkg::mem_req_t mem_req;
    amacc_pkg::acc_t     rd_data;
    logic                clearing;

    amacc_mem u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mem_req),
        .rd_data  (rd_data),
        .clearing (clearing)
    );

    amacc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .rd_data   (rd_data),
        .clearing  (clearing)
    );

endmodule

FILE: rtl/amacc_checker.sv
// ----------------------------------------------------------------------------
// Audio mix accumulator checker
// Port-level assertions on the mix accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "audio_mix_accumulator_macros.svh"

module amacc_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            cmd_valid,
    input logic            cmd_ready,
    input amacc_pkg::cmd_t cmd,
    input logic            res_valid,
    input logic            res_ready,
    input amacc_pkg::res_t res
);

    `AMACC_ASSERT_NXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res))
    `AMACC_ASSERT_IMP(a_empty_zero, clk, rst_n, res_valid && res.empty_res, res.raw_sum == 24'sd0 && res.clamped_sample == 16'sd0 && !res.last)
    `AMACC_ASSERT_IMP(a_clamp_range, clk, rst_n, res_valid, res.clamped_sample != 16'sh8000)
    `AMACC_ASSERT_NXT(a_one_at_a_time, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready)

endmodule

bind audio_mix_accumulator amacc_checker u_amacc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
